// ----- rtl/tnf_pkg.sv -----
// ----------------------------------------------------------------------------
// tnf_pkg
// Shared types and constants for the tracking notch filter.
// ----------------------------------------------------------------------------
package tnf_pkg;

  localparam int unsigned SampleWidthDef  = 16;
  localparam int unsigned CoefFracBitsDef = 30;
  localparam int unsigned FreqWidth       = 17;
  localparam int unsigned CfgIdxWidth     = 2;
  localparam int unsigned CfgDataWidth    = 32;
  // Gains, numerators and denominator (gains reach 2^50, sums stay below 2^51)
  localparam int unsigned GainWidth       = 52;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegSamplePeriod = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegWidthCoef    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegDepthCoef    = 2'd2;

  localparam logic [31:0] SamplePeriodRst = 32'd214748;
  localparam logic [15:0] WidthCoefRst    = 16'd256;
  localparam logic [15:0] DepthCoefRst    = 16'd0;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StGain,   // saturate T*W, form the three products
    StSetup,  // form numerators and denominator
    StDiv,    // run the four divisions
    StMac,    // accumulate the four products
    StRound,  // round and saturate
    StOut     // present result
  } state_e;

  // Divider control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ----- rtl/tnf_div.sv -----
// ----------------------------------------------------------------------------
// tnf_div
// Restoring divider: signed numerator over positive denominator, Q2.F
// quotient, truncated toward zero, saturated below magnitude two. One bit/cycle.
// ----------------------------------------------------------------------------
module tnf_div #(
  parameter int unsigned CoefFracBits = tnf_pkg::CoefFracBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tnf_pkg::GainWidth-1:0] num_i,
  input  logic        [tnf_pkg::GainWidth-1:0] den_i,
  output tnf_pkg::div_ctl_t                    ctl_o,
  output logic signed [CoefFracBits+2:0]       quot_o
);

  localparam int unsigned GW  = tnf_pkg::GainWidth;
  localparam int unsigned MW  = GW + 1;
  localparam int unsigned QW  = CoefFracBits + 2;
  localparam int unsigned CW  = $clog2(CoefFracBits + 1);
  localparam logic [QW-1:0] Cap = {1'b0, {(QW-1){1'b1}}};

  logic [MW-1:0] rem_q, rem_d;
  logic [GW-1:0] den_q;
  logic [QW-1:0] q_q, q_d;
  logic          neg_q, busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [MW-1:0] mag;
  logic [MW-1:0] sh;

  assign mag = num_i[GW-1] ? MW'(-num_i) : MW'(num_i);
  assign sh  = {rem_q[GW-1:0], 1'b0};

  // One shift-subtract step
  always_comb begin
    rem_d = sh;
    q_d   = {q_q[QW-2:0], 1'b0};
    if (sh >= {1'b0, den_q}) begin
      rem_d = sh - {1'b0, den_q};
      q_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        neg_q <= num_i[GW-1];
        den_q <= den_i;
        if (mag >= {den_i, 1'b0}) begin
          q_q    <= Cap;
          done_q <= 1'b1;
        end else if (mag >= {1'b0, den_i}) begin
          q_q    <= QW'(1);
          rem_q  <= mag - {1'b0, den_i};
          busy_q <= 1'b1;
          cnt_q  <= CW'(CoefFracBits);
        end else begin
          q_q    <= '0;
          rem_q  <= mag;
          busy_q <= 1'b1;
          cnt_q  <= CW'(CoefFracBits);
        end
      end else if (busy_q) begin
        rem_q <= rem_d;
        q_q   <= q_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

// ----- rtl/tracking_notch_filter.sv -----
// Sequence: after the input transaction the block runs four gain steps, setup,
// four divider runs (cut short when the quotient saturates), four MAC steps
// and rounding before out_valid_o rises. A new transaction is taken only
// once the last result has been delivered; in_ready_o is low while busy and a
// waiting result holds the block. Reset (async, active low) clears history,
// sequencer and loads register defaults.
// ----------------------------------------------------------------------------
// tracking_notch_filter
// Per-sample bilinear notch biquad with a shared divider and multiplier.
// ----------------------------------------------------------------------------
module tracking_notch_filter #(
  parameter int unsigned SampleWidth  = tnf_pkg::SampleWidthDef,
  parameter int unsigned CoefFracBits = tnf_pkg::CoefFracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tnf_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [tnf_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SampleWidth-1:0]       sample_in_i,
  input  logic [tnf_pkg::FreqWidth-1:0]       notch_freq_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SampleWidth-1:0]       sample_out_o
);

  localparam int unsigned QW  = CoefFracBits + 3;     // signed quotient width
  localparam int unsigned DW  = SampleWidth + 2;      // difference width
  localparam int unsigned PW  = QW + DW;
  localparam int unsigned AW  = PW + 3;
  localparam int unsigned GW  = tnf_pkg::GainWidth;
  localparam logic [GW-1:0] Four = GW'(64'h4_0000_0000);  // 4.0 in Q.32

  // Configuration registers
  logic [31:0] period_q;
  logic [15:0] width_q, depth_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= tnf_pkg::SamplePeriodRst;
      width_q  <= tnf_pkg::WidthCoefRst;
      depth_q  <= tnf_pkg::DepthCoefRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tnf_pkg::RegSamplePeriod: period_q <= cfg_data_i;
        tnf_pkg::RegWidthCoef:    width_q  <= cfg_data_i[15:0];
        tnf_pkg::RegDepthCoef:    depth_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  tnf_pkg::state_e state_q, state_d;
  logic [1:0] sel_q, sel_d;   // division / mac index
  logic signed [SampleWidth-1:0] x0_q, x1_q, x2_q, y1_q, y2_q, res_q;
  logic [48:0] xw_q;
  logic [39:0] x_q;
  logic [GW-1:0] a0_q, a1_q, t2_q, num_q, den_q;
  logic signed [QW-1:0] coef_q [4];
  logic signed [AW-1:0] acc_q;
  logic [1:0] sub_q;          // gain sub-step

  // Shared 40x32 multiplier (one product per cycle, operand select by sub-step)
  logic [39:0] ma;
  logic [31:0] mb;
  logic [71:0] mp;
  always_comb begin
    ma = x_q;
    mb = {16'd0, width_q};
    case (sub_q)
      2'd0: mb = {16'd0, width_q};
      2'd1: mb = {16'd0, depth_q};
      2'd2: begin ma = {8'd0, x_q[39:8]}; mb = x_q[39:8]; end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  // Divider
  logic signed [GW-1:0] dnum;
  tnf_pkg::div_ctl_t dctl;
  logic dstart;
  logic div_go;
  logic signed [QW-1:0] dq;
  always_comb begin
    case (sel_q)
      2'd0: dnum = $signed(num_q + a1_q);
      2'd1: dnum = $signed({t2_q[GW-2:0], 1'b0}) - $signed(Four);
      2'd2: dnum = $signed(num_q) - $signed(a1_q);
      default: dnum = $signed(num_q) - $signed(a0_q);
    endcase
  end
  tnf_div #(.CoefFracBits(CoefFracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_go), .num_i(dnum), .den_i(den_q),
    .ctl_o(dctl), .quot_o(dq)
  );

  // MAC operand
  logic signed [DW-1:0] mop;
  logic signed [QW-1:0] mcoef;
  logic signed [PW-1:0] mprod;
  always_comb begin
    mcoef = coef_q[sel_q];
    case (sel_q)
      2'd0: mop = DW'(x0_q);
      2'd1: mop = DW'(x1_q) - DW'(y1_q);
      2'd2: mop = DW'(x2_q);
      default: begin mop = -DW'(y2_q); end
    endcase
  end
  assign mprod = PW'(mcoef) * PW'(mop);

  // Rounding and saturation
  logic signed [AW-1:0] rnd, shr;
  logic signed [SampleWidth-1:0] sat;
  localparam logic signed [AW-1:0] MaxP = AW'((64'd1 << (SampleWidth-1)) - 1);
  localparam logic signed [AW-1:0] MinN = -MaxP - AW'(1);
  assign rnd = acc_q + (AW'(1) <<< (CoefFracBits-1));
  assign shr = rnd >>> CoefFracBits;
  always_comb begin
    if (shr > MaxP)      sat = MaxP[SampleWidth-1:0];
    else if (shr < MinN) sat = MinN[SampleWidth-1:0];
    else                 sat = shr[SampleWidth-1:0];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    dstart  = 1'b0;
    case (state_q)
      tnf_pkg::StIdle:  if (in_valid_i) state_d = tnf_pkg::StGain;
      tnf_pkg::StGain:  if (sub_q == 2'd2) state_d = tnf_pkg::StSetup;
      tnf_pkg::StSetup: begin state_d = tnf_pkg::StDiv; sel_d = 2'd0; dstart = 1'b1; end
      tnf_pkg::StDiv: begin
        if (dctl.done) begin
          if (sel_q == 2'd3) begin
            state_d = tnf_pkg::StMac;
            sel_d   = 2'd0;
          end else begin
            sel_d  = sel_q + 2'd1;
          end
        end
      end
      tnf_pkg::StMac:   if (sel_q == 2'd3) state_d = tnf_pkg::StRound;
                        else sel_d = sel_q + 2'd1;
      tnf_pkg::StRound: state_d = tnf_pkg::StOut;
      tnf_pkg::StOut:   if (out_ready_i) state_d = tnf_pkg::StIdle;
      default:          state_d = tnf_pkg::StIdle;
    endcase
  end

  // Restart divider the cycle after a done, when more remain
  logic restart_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tnf_pkg::StIdle;
      sel_q   <= '0;
      sub_q   <= '0;
      restart_q <= 1'b0;
      x1_q <= '0; x2_q <= '0; y1_q <= '0; y2_q <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      restart_q <= (state_q == tnf_pkg::StDiv) && dctl.done && (sel_q != 2'd3);
      case (state_q)
        tnf_pkg::StIdle: if (in_valid_i) begin
          x0_q  <= sample_in_i;
          xw_q  <= 49'(period_q) * 49'(notch_freq_i);
          sub_q <= 2'd3;
        end
        tnf_pkg::StGain: begin
          if (sub_q == 2'd3) x_q <= (xw_q > 49'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : xw_q[39:0];
          else if (sub_q == 2'd0) a0_q <= GW'(mp >> 6);
          else if (sub_q == 2'd1) a1_q <= GW'(mp >> 6);
          else t2_q <= GW'(mp >> 16);
          sub_q <= sub_q + 2'd1;
        end
        tnf_pkg::StSetup: begin
          num_q <= Four + t2_q;
          den_q <= Four + t2_q + a0_q;
        end
        tnf_pkg::StDiv: begin
          if (dctl.done) coef_q[sel_q] <= dq;
          acc_q <= '0;
        end
        tnf_pkg::StMac:   acc_q <= acc_q + AW'(mprod);
        tnf_pkg::StRound: begin
          res_q <= sat;
          x2_q <= x1_q; x1_q <= x0_q;
          y2_q <= y1_q; y1_q <= sat;
        end
        default: ;
      endcase
    end
  end

  // The divider start for the first run needs num/den registered, so it is
  // issued from StSetup only after den_q lands: delayed through first_q.
  logic first_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) first_q <= 1'b0;
    else         first_q <= dstart;
  end

  assign div_go = first_q || restart_q;

  assign in_ready_o   = (state_q == tnf_pkg::StIdle);
  assign out_valid_o  = (state_q == tnf_pkg::StOut);
  assign sample_out_o = res_q;

  // div_go drives the divider start (dstart only marks setup)
  tnf_div_start_unused_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_go && dctl.busy)) else $error("divider restarted while busy");

endmodule

// ----- rtl/tnf_checker.sv -----
// ----------------------------------------------------------------------------
// tnf_checker
// Port-level checks of the tracking notch filter.
// ----------------------------------------------------------------------------
module tnf_checker #(
  parameter int unsigned SampleWidth = tnf_pkg::SampleWidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic signed [SampleWidth-1:0] sample_out_o
);

  // Never accept input while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready with result pending");

  // No result right after accepting
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too early");

  // Result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sample_out_o)))
    else $error("result dropped");

  // After delivery the block becomes ready again
  a_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o) else $error("not ready after output");

endmodule

bind tracking_notch_filter tnf_checker #(.SampleWidth(SampleWidth)) u_tnf_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .sample_out_o
);
